// ===== design/crcpf_pkg.sv =====
`default_nettype none

package crcpf_pkg;

   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [31:0] PAIRING_KEY = 32'h54D2EE63;

   // one input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
      logic       use_pairing_key;
   } req_type;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_check_byte;
      logic       packet_end;
   } rsp_type;

   // classified item handed from front to back, crc already includes data_byte
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        final_byte;
      logic        use_pairing_key;
      logic [15:0] crc;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // what the output register currently holds
   typedef enum logic [1:0] {
      PH_ECHO,
      PH_HIGH,
      PH_LOW
   } phase_type;

   // msb-first crc-16 update over one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] r;
      r = crc;
      for (int k = 7; k >= 0; k--) begin
         if (r[15] ^ data[k]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   // two bytes, high byte first
   function automatic logic [15:0] crc_half(input logic [15:0] crc, input logic [15:0] data);
      logic [15:0] r;
      r = crc_byte(crc, data[15:8]);
      r = crc_byte(r, data[7:0]);
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/crcpf_front.sv =====
`default_nettype none

module crcpf_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire crcpf_pkg::req_type   req_data,
   input  wire logic                 q_full,
   output logic                      q_push,
   output crcpf_pkg::entry_type      q_entry
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] crc_next;

   assign crc_next = crcpf_pkg::crc_byte(crc_ff, req_data.data_byte);
   assign q_push   = push && !q_full;

   always_comb begin
      q_entry.data_byte       = req_data.data_byte;
      q_entry.final_byte      = req_data.final_byte;
      q_entry.use_pairing_key = req_data.use_pairing_key;
      q_entry.crc             = crc_next;
   end

   // running crc restarts after the last byte of a packet
   always_comb begin
      crc_in = crc_ff;
      if (q_push) begin
         crc_in = req_data.final_byte ? crcpf_pkg::CRC_INIT : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= crcpf_pkg::CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/crcpf_queue.sv =====
`default_nettype none

module crcpf_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    wr_en,
   input  wire crcpf_pkg::entry_type    wr_entry,
   input  wire logic                    rd_en,
   output crcpf_pkg::entry_type         rd_entry,
   output crcpf_pkg::queue_status_type  status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   crcpf_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_wr, do_rd;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_wr        = wr_en && !status.full;
   assign do_rd        = rd_en && !status.empty;
   assign rd_entry     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

`default_nettype wire

// ===== design/crcpf_back.sv =====
`default_nettype none

module crcpf_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [31:0]           client_key,
   input  wire logic                  q_empty,
   input  wire crcpf_pkg::entry_type  q_entry,
   output logic                       q_pop,
   input  wire logic                  pop,
   output logic                       empty,
   output crcpf_pkg::rsp_type         rsp_data
);

   crcpf_pkg::phase_type phase_ff, phase_in;
   logic               out_valid_ff, out_valid_in;
   crcpf_pkg::rsp_type out_ff, out_in;
   logic [15:0]        crc_ff, crc_in;
   logic [15:0]        key_lo_ff, key_lo_in;
   logic               final_ff, final_in;
   logic [31:0]        key_sel;
   logic [15:0]        crc_fin;
   logic               out_free, load_high, load_low;

   assign out_free  = !out_valid_ff || pop;
   assign load_high = out_valid_ff && (phase_ff == crcpf_pkg::PH_ECHO) && final_ff;
   assign load_low  = out_valid_ff && (phase_ff == crcpf_pkg::PH_HIGH);
   assign q_pop     = out_free && !load_high && !load_low && !q_empty;
   assign key_sel   = q_entry.use_pairing_key ? crcpf_pkg::PAIRING_KEY : client_key;
   assign crc_fin   = crcpf_pkg::crc_half(crc_ff, key_lo_ff);

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   // next state
   always_comb begin
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = load_high || load_low || q_pop;
         if (load_high) begin
            phase_in = crcpf_pkg::PH_HIGH;
         end else if (load_low) begin
            phase_in = crcpf_pkg::PH_LOW;
         end else if (q_pop) begin
            phase_in = crcpf_pkg::PH_ECHO;
         end
      end
   end

   // datapath: key folded in two halves, upper half at dequeue
   always_comb begin
      out_in    = out_ff;
      crc_in    = crc_ff;
      key_lo_in = key_lo_ff;
      final_in  = final_ff;
      if (out_free) begin
         if (load_high) begin
            crc_in = crc_fin;
            out_in = '{out_byte: crc_fin[15:8], is_check_byte: 1'b1, packet_end: 1'b0};
         end else if (load_low) begin
            out_in = '{out_byte: crc_ff[7:0], is_check_byte: 1'b1, packet_end: 1'b1};
         end else if (q_pop) begin
            crc_in    = crcpf_pkg::crc_half(q_entry.crc, key_sel[31:16]);
            key_lo_in = key_sel[15:0];
            final_in  = q_entry.final_byte;
            out_in    = '{out_byte: q_entry.data_byte, is_check_byte: 1'b0, packet_end: 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= crcpf_pkg::PH_ECHO;
         out_valid_ff <= 1'b0;
         final_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         final_ff     <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff    <= out_in;
      crc_ff    <= crc_in;
      key_lo_ff <= key_lo_in;
   end

endmodule

`default_nettype wire

// ===== design/crc16_keyed_packet_framer.sv =====
// flow: an accepted byte goes into the queue, then shows as its echo in the output
// register; crc high and low follow on the next two output transfers, key fold split
// over dequeue and high load. throughput: one non-final byte per cycle while popped;
// a final byte adds two check bytes, the single output register showing one at a time
// reset: synchronous active high; clears the queue, empties the output and sets
// the running crc to 0xffff and client_key to 0
`default_nettype none

module crc16_keyed_packet_framer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // input channel
   input  wire logic                push,
   output logic                     full,
   input  wire crcpf_pkg::req_type  req_data,
   // result channel
   output logic                     empty,
   input  wire logic                pop,
   output crcpf_pkg::rsp_type       rsp_data,
   // client key write
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [31:0]         csr_wdata
);

   logic [31:0]                 client_key_ff, client_key_in;
   logic                        q_push, q_pop;
   crcpf_pkg::entry_type        q_wr_entry, q_rd_entry;
   crcpf_pkg::queue_status_type q_status;

   // key register always takes a transfer
   assign csr_ready     = 1'b1;
   assign client_key_in = (csr_valid && csr_ready) ? csr_wdata : client_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         client_key_ff <= '0;
      end else begin
         client_key_ff <= client_key_in;
      end
   end

   // input side stalls only when the queue is full
   assign full = q_status.full;

   // front: running crc and classification of each byte
   crcpf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .q_full   (q_status.full),
      .q_push   (q_push),
      .q_entry  (q_wr_entry)
   );

   // decoupling queue between front and back
   crcpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_entry (q_wr_entry),
      .rd_en    (q_pop),
      .rd_entry (q_rd_entry),
      .status   (q_status)
   );

   // back: echo, key fold and check bytes
   crcpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .client_key (client_key_ff),
      .q_empty    (q_status.empty),
      .q_entry    (q_rd_entry),
      .q_pop      (q_pop),
      .pop        (pop),
      .empty      (empty),
      .rsp_data   (rsp_data)
   );

   // queue can never claim to be full and empty at once
   assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty together");

   // crc high byte transfer is always followed by the low byte right away
   assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && rsp_data.is_check_byte && !rsp_data.packet_end)
      |=> (!empty && rsp_data.is_check_byte && rsp_data.packet_end))
      else $error("crc low byte missing after high byte");

   // end of packet only on a check byte
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.packet_end) |-> rsp_data.is_check_byte)
      else $error("packet end on a payload byte");

   // leaving reset, input side is open
   assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !full)
      else $error("full right after reset");

endmodule

`default_nettype wire

// ===== test/crc16_keyed_packet_framer_tb.sv =====
`timescale 1ns / 100ps

module crc16_keyed_packet_framer_tb;

   // clock, reset and block ports; all but the block outputs known from time zero
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   crcpf_pkg::req_type req_data = '0;
   logic               empty;
   logic               pop = 1'b0;
   crcpf_pkg::rsp_type rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [31:0]        csr_wdata = '0;

   // predictor state: running crc and the shadow of the client key register
   logic [15:0] crc_acc = crcpf_pkg::CRC_INIT;
   logic [31:0] client_key_shadow = '0;

   // framed bytes still to come out of the block, oldest first
   crcpf_pkg::rsp_type pending_bytes[$];

   int          error_count = 0;
   // idle rates in percent, per side
   int          req_idle_pct = 9;
   int          rsp_idle_pct = 9;
   // receiver hold-off request in cycles, picked up by the receiver process
   int          rsp_hold_req = 0;
   int          rsp_hold_left = 0;

   crc16_keyed_packet_framer i_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // safety net against a hung handshake
   initial begin
      #400000;
      $display("crc16_keyed_packet_framer_tb NOT OK");
      $finish;
   end

   // crc-16 msb first, byte xored into the top and shifted out bit by bit
   function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] v;
      int          i;
      v = acc ^ {b, 8'h00};
      for (i = 0; i < 8; i++) begin
         if (v[15]) begin
            v = {v[14:0], 1'b0} ^ crcpf_pkg::CRC_POLY;
         end else begin
            v = {v[14:0], 1'b0};
         end
      end
      return v;
   endfunction

   // works out what one accepted byte produces: its echo, and on the last byte
   // the keyed crc high and low bytes
   task automatic frame_byte(input crcpf_pkg::req_type r);
      logic [15:0]        c;
      logic [31:0]        key;
      crcpf_pkg::rsp_type o;
      c = crc_step(crc_acc, r.data_byte);
      o.out_byte      = r.data_byte;
      o.is_check_byte = 1'b0;
      o.packet_end    = 1'b0;
      pending_bytes.insert(pending_bytes.size(), o);
      if (!r.final_byte) begin
         // key select is a don't care until the last byte
         crc_acc = c;
      end else begin
         key = r.use_pairing_key ? crcpf_pkg::PAIRING_KEY : client_key_shadow;
         // key folds in big-endian and never shows on the wire
         c = crc_step(c, key[31:24]);
         c = crc_step(c, key[23:16]);
         c = crc_step(c, key[15:8]);
         c = crc_step(c, key[7:0]);
         o.out_byte      = c[15:8];
         o.is_check_byte = 1'b1;
         o.packet_end    = 1'b0;
         pending_bytes.insert(pending_bytes.size(), o);
         o.out_byte   = c[7:0];
         o.packet_end = 1'b1;
         pending_bytes.insert(pending_bytes.size(), o);
         crc_acc = crcpf_pkg::CRC_INIT;
      end
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   // receiver: checks each transfer against the oldest expectation, then
   // decides whether to pop in the next cycle
   always @(posedge clock) begin
      crcpf_pkg::rsp_type exp_byte;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (pending_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected output byte %02h", rsp_data.out_byte));
            end else begin
               exp_byte = pending_bytes.pop_front();
               if (rsp_data.out_byte !== exp_byte.out_byte) begin
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_data.out_byte, exp_byte.out_byte));
               end
               if (rsp_data.is_check_byte !== exp_byte.is_check_byte) begin
                  report_mismatch($sformatf("is_check_byte %b, want %b",
                                            rsp_data.is_check_byte, exp_byte.is_check_byte));
               end
               if (rsp_data.packet_end !== exp_byte.packet_end) begin
                  report_mismatch($sformatf("packet_end %b, want %b",
                                            rsp_data.packet_end, exp_byte.packet_end));
               end
            end
         end
         // a hold-off request overrides random idling for its whole length
         if (rsp_hold_req > 0) begin
            rsp_hold_left = rsp_hold_req;
            rsp_hold_req  = 0;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // offers one byte, with a random gap in front, and waits for its transfer;
   // push stays high on return so back-to-back bytes need no second drive
   task automatic send_byte(input logic [7:0] data, input logic fin, input logic pairing);
      crcpf_pkg::req_type r;
      r.data_byte       = data;
      r.final_byte      = fin;
      r.use_pairing_key = pairing;
      while ($urandom_range(99) < req_idle_pct) begin
         // junk on the bus while push is low must be ignored
         push     <= 1'b0;
         req_data <= crcpf_pkg::req_type'($urandom);
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      frame_byte(r);
   endtask

   // sender pause: nothing offered until every expected byte has come out
   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (pending_bytes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // only called with the block drained
   task automatic write_client_key(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      client_key_shadow = value;
   endtask

   // key out of reset is zero; single-byte packets at both byte extremes
   task automatic test_reset_key();
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b0);
      send_byte(8'h00, 1'b1, 1'b1);
   endtask

   // all-ones and all-zeros keys, pairing select on non-final bytes, a mid key
   task automatic test_key_extremes();
      int i;
      wait_drained();
      write_client_key(32'hFFFF_FFFF);
      // ascii check string, pairing flag set on bytes where it must not matter
      for (i = 0; i < 9; i++) begin
         send_byte(8'(8'h31 + i), i == 8, i != 8);
      end
      send_byte(8'h80, 1'b1, 1'b1);
      wait_drained();
      write_client_key(32'h0000_0000);
      send_byte(8'h01, 1'b0, 1'b1);
      send_byte(8'h7F, 1'b0, 1'b0);
      send_byte(8'hFE, 1'b1, 1'b0);
      wait_drained();
      write_client_key(32'h1234_5678);
      send_byte(8'hA5, 1'b0, 1'b0);
      send_byte(8'h5A, 1'b1, 1'b0);
   endtask

   // random packets, mostly short, some long; last packet cut to fit the count
   task automatic test_random_packets(input logic [31:0] key, input int n_items);
      int sent;
      int len;
      int k;
      sent = 0;
      wait_drained();
      write_client_key(key);
      while (sent < n_items) begin
         len = ($urandom_range(9) < 8) ? $urandom_range(6, 1) : $urandom_range(24, 7);
         if (len > n_items - sent) begin
            len = n_items - sent;
         end
         for (k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(255)), k == len - 1, 1'($urandom_range(1)));
         end
         sent += len;
      end
   endtask

   // receiver stops for a long stretch while bytes keep coming, so the input
   // side fills and stalls
   task automatic test_backpressure();
      wait_drained();
      rsp_hold_req = 80;
      test_random_packets($urandom, 25);
      wait_drained();
   endtask

   // a stretch with no idling on either side
   task automatic test_no_idle();
      wait_drained();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_packets($urandom, 30);
      wait_drained();
      req_idle_pct = 9;
      rsp_idle_pct = 9;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_key();
      test_key_extremes();
      test_random_packets(32'hFFFF_FFFF, 45);
      test_random_packets($urandom, 21);
      test_random_packets(32'h0000_0000, 30);
      test_backpressure();
      test_no_idle();
      // let any stray transfer show up before the verdict
      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("crc16_keyed_packet_framer_tb OK");
      end else begin
         $display("crc16_keyed_packet_framer_tb NOT OK");
      end
      $finish;
   end

endmodule
